[src/cpu6502_execute_unit_defines.svh]
// assertion macros used by the execute unit rtl
`ifndef CPU6502_EXECUTE_UNIT_DEFINES_SVH
`define CPU6502_EXECUTE_UNIT_DEFINES_SVH

`ifndef SYNTH
// clocked check, aborted while reset is high
`define CEU_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds during reset
`define CEU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CEU_ASSERT_RST(lbl, clk, rst, prop, msg)
`define CEU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[src/ceu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ceu_pkg;

   typedef enum logic [5:0] {
      OP_ADC = 6'd0, OP_AND, OP_ASL, OP_BCC, OP_BCS, OP_BEQ, OP_BIT, OP_BMI,
      OP_BNE, OP_BPL, OP_BVC, OP_BVS, OP_CLC, OP_CLD, OP_CLI, OP_CLV,
      OP_CMP, OP_CPX, OP_CPY, OP_DEC, OP_DEX, OP_DEY, OP_EOR, OP_INC,
      OP_INX, OP_INY, OP_JMP, OP_LDA, OP_LDX, OP_LDY, OP_NOP, OP_ORA,
      OP_SBC, OP_SEC, OP_SED, OP_SEI, OP_STA, OP_STX, OP_STY, OP_TAX,
      OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA
   } op_type;

   localparam logic [1:0] EXTRA_NONE   = 2'd0;
   localparam logic [1:0] EXTRA_BRANCH = 2'd1;
   localparam logic [1:0] EXTRA_BRPAGE = 2'd2;

   typedef struct packed {
      logic n;
      logic v;
      logic d;
      logic i;
      logic z;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      flags_type  flags;
   } state_type;

   typedef struct packed {
      logic [5:0]  req_type;
      logic [7:0]  operand;
      logic [15:0] eff_addr;
      logic [15:0] jump_target;
      logic [15:0] current_pc;
      logic        page_crossed;
   } req_item_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        mem_write;
      logic [15:0] write_addr;
      logic [7:0]  write_data;
      logic [1:0]  extra_cycles;
      logic [7:0]  acc_value;
      logic [7:0]  x_value;
      logic [7:0]  y_value;
      logic [7:0]  sp_value;
      logic [7:0]  status_byte;
   } rsp_item_type;

endpackage

`default_nettype wire

[src/ceu_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// instruction channel
interface ceu_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  req_type;
   logic [7:0]  operand;
   logic [15:0] eff_addr;
   logic [15:0] jump_target;
   logic [15:0] current_pc;
   logic        page_crossed;

   modport source (output valid, req_type, operand, eff_addr, jump_target, current_pc,
                   page_crossed, input ready);
   modport sink (input valid, req_type, operand, eff_addr, jump_target, current_pc,
                 page_crossed, output ready);
endinterface

// result channel
interface ceu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] next_pc;
   logic        mem_write;
   logic [15:0] write_addr;
   logic [7:0]  write_data;
   logic [1:0]  extra_cycles;
   logic [7:0]  acc_value;
   logic [7:0]  x_value;
   logic [7:0]  y_value;
   logic [7:0]  sp_value;
   logic [7:0]  status_byte;

   modport source (output valid, next_pc, mem_write, write_addr, write_data, extra_cycles,
                   acc_value, x_value, y_value, sp_value, status_byte, input ready);
   modport sink (input valid, next_pc, mem_write, write_addr, write_data, extra_cycles,
                 acc_value, x_value, y_value, sp_value, status_byte, output ready);
endinterface

`default_nettype wire

[src/ceu_alu.sv]
`timescale 1ns / 1ps
`default_nettype none

module ceu_alu (
   input  ceu_pkg::req_item_type item,
   input  ceu_pkg::state_type    cur,
   output ceu_pkg::state_type    nxt,
   output ceu_pkg::rsp_item_type result
);

   ceu_pkg::op_type op;
   logic [7:0]      add_val;
   logic [8:0]      sum;
   logic [7:0]      cmp_reg;
   logic [8:0]      diff;
   logic [15:0]     br_target;
   logic            taken;
   logic            wr;
   logic [7:0]      wdata;
   logic [7:0]      zn_val;
   logic            zn_upd;
   logic [1:0]      extra;
   logic [15:0]     npc;

   assign op      = ceu_pkg::op_type'(item.req_type);
   assign add_val = (op == ceu_pkg::OP_SBC) ? ~item.operand : item.operand;
   assign sum     = {1'b0, cur.acc} + {1'b0, add_val} + {8'd0, cur.flags.c};
   assign cmp_reg = (op == ceu_pkg::OP_CPX) ? cur.x :
                    (op == ceu_pkg::OP_CPY) ? cur.y : cur.acc;
   assign diff    = {1'b0, cmp_reg} - {1'b0, item.operand};
   assign br_target = item.current_pc + {{8{item.operand[7]}}, item.operand};

   always_comb begin
      nxt    = cur;
      taken  = 1'b0;
      wr     = 1'b0;
      wdata  = 8'd0;
      zn_val = 8'd0;
      zn_upd = 1'b0;
      case (op)
         ceu_pkg::OP_ADC, ceu_pkg::OP_SBC: begin
            nxt.acc     = sum[7:0];
            nxt.flags.c = sum[8];
            nxt.flags.v = ~(cur.acc[7] ^ add_val[7]) & (cur.acc[7] ^ sum[7]);
            zn_val      = sum[7:0];
            zn_upd      = 1'b1;
         end
         ceu_pkg::OP_AND: begin
            nxt.acc = cur.acc & item.operand;
            zn_val  = nxt.acc;
            zn_upd  = 1'b1;
         end
         ceu_pkg::OP_ORA: begin
            nxt.acc = cur.acc | item.operand;
            zn_val  = nxt.acc;
            zn_upd  = 1'b1;
         end
         ceu_pkg::OP_EOR: begin
            nxt.acc = cur.acc ^ item.operand;
            zn_val  = nxt.acc;
            zn_upd  = 1'b1;
         end
         ceu_pkg::OP_ASL: begin
            nxt.flags.c = cur.acc[7];
            nxt.acc     = {cur.acc[6:0], 1'b0};
            zn_val      = nxt.acc;
            zn_upd      = 1'b1;
         end
         ceu_pkg::OP_BCC: taken = ~cur.flags.c;
         ceu_pkg::OP_BCS: taken = cur.flags.c;
         ceu_pkg::OP_BEQ: taken = cur.flags.z;
         ceu_pkg::OP_BNE: taken = ~cur.flags.z;
         ceu_pkg::OP_BMI: taken = cur.flags.n;
         ceu_pkg::OP_BPL: taken = ~cur.flags.n;
         ceu_pkg::OP_BVS: taken = cur.flags.v;
         ceu_pkg::OP_BVC: taken = ~cur.flags.v;
         ceu_pkg::OP_BIT: begin
            nxt.flags.z = (cur.acc & item.operand) == 8'd0;
            nxt.flags.v = item.operand[6];
            nxt.flags.n = item.operand[7];
         end
         ceu_pkg::OP_CLC: nxt.flags.c = 1'b0;
         ceu_pkg::OP_CLD: nxt.flags.d = 1'b0;
         ceu_pkg::OP_CLI: nxt.flags.i = 1'b0;
         ceu_pkg::OP_CLV: nxt.flags.v = 1'b0;
         ceu_pkg::OP_SEC: nxt.flags.c = 1'b1;
         ceu_pkg::OP_SED: nxt.flags.d = 1'b1;
         ceu_pkg::OP_SEI: nxt.flags.i = 1'b1;
         ceu_pkg::OP_CMP, ceu_pkg::OP_CPX, ceu_pkg::OP_CPY: begin
            nxt.flags.c = ~diff[8];
            nxt.flags.z = cmp_reg == item.operand;
            nxt.flags.n = diff[7];
         end
         ceu_pkg::OP_DEC: begin
            wr     = 1'b1;
            wdata  = item.operand - 8'd1;
            zn_val = wdata;
            zn_upd = 1'b1;
         end
         ceu_pkg::OP_INC: begin
            wr     = 1'b1;
            wdata  = item.operand + 8'd1;
            zn_val = wdata;
            zn_upd = 1'b1;
         end
         ceu_pkg::OP_DEX: begin
            nxt.x  = cur.x - 8'd1;
            zn_val = nxt.x;
            zn_upd = 1'b1;
         end
         ceu_pkg::OP_DEY: begin
            nxt.y  = cur.y - 8'd1;
            zn_val = nxt.y;
            zn_upd = 1'b1;
         end
         ceu_pkg::OP_INX: begin
            nxt.x  = cur.x + 8'd1;
            zn_val = nxt.x;
            zn_upd = 1'b1;
         end
         ceu_pkg::OP_INY: begin
            nxt.y  = cur.y + 8'd1;
            zn_val = nxt.y;
            zn_upd = 1'b1;
         end
         ceu_pkg::OP_LDA: begin
            nxt.acc = item.operand;
            zn_val  = item.operand;
            zn_upd  = 1'b1;
         end
         ceu_pkg::OP_LDX: begin
            nxt.x  = item.operand;
            zn_val = item.operand;
            zn_upd = 1'b1;
         end
         ceu_pkg::OP_LDY: begin
            nxt.y  = item.operand;
            zn_val = item.operand;
            zn_upd = 1'b1;
         end
         ceu_pkg::OP_STA: begin
            wr    = 1'b1;
            wdata = cur.acc;
         end
         ceu_pkg::OP_STX: begin
            wr    = 1'b1;
            wdata = cur.x;
         end
         ceu_pkg::OP_STY: begin
            wr    = 1'b1;
            wdata = cur.y;
         end
         ceu_pkg::OP_TAX: begin
            nxt.x  = cur.acc;
            zn_val = cur.acc;
            zn_upd = 1'b1;
         end
         ceu_pkg::OP_TAY: begin
            nxt.y  = cur.acc;
            zn_val = cur.acc;
            zn_upd = 1'b1;
         end
         ceu_pkg::OP_TSX: begin
            nxt.x  = cur.sp;
            zn_val = cur.sp;
            zn_upd = 1'b1;
         end
         ceu_pkg::OP_TXA: begin
            nxt.acc = cur.x;
            zn_val  = cur.x;
            zn_upd  = 1'b1;
         end
         ceu_pkg::OP_TYA: begin
            nxt.acc = cur.y;
            zn_val  = cur.y;
            zn_upd  = 1'b1;
         end
         ceu_pkg::OP_TXS: nxt.sp = cur.x;
         default: ;
      endcase
      if (zn_upd) begin
         nxt.flags.z = zn_val == 8'd0;
         nxt.flags.n = zn_val[7];
      end
   end

   always_comb begin
      npc   = item.current_pc;
      extra = ceu_pkg::EXTRA_NONE;
      if (op == ceu_pkg::OP_JMP) begin
         npc = item.jump_target;
      end
      if (op inside {ceu_pkg::OP_ADC, ceu_pkg::OP_AND, ceu_pkg::OP_CMP, ceu_pkg::OP_EOR,
                     ceu_pkg::OP_LDA, ceu_pkg::OP_LDX, ceu_pkg::OP_LDY, ceu_pkg::OP_ORA,
                     ceu_pkg::OP_SBC}) begin
         extra = {1'b0, item.page_crossed};
      end
      if (taken) begin
         npc   = br_target;
         extra = item.page_crossed ? ceu_pkg::EXTRA_BRPAGE : ceu_pkg::EXTRA_BRANCH;
      end
   end

   assign result.next_pc      = npc;
   assign result.mem_write    = wr;
   assign result.write_addr   = wr ? item.eff_addr : 16'd0;
   assign result.write_data   = wdata;
   assign result.extra_cycles = extra;
   assign result.acc_value    = nxt.acc;
   assign result.x_value      = nxt.x;
   assign result.y_value      = nxt.y;
   assign result.sp_value     = nxt.sp;
   assign result.status_byte  = {nxt.flags.n, nxt.flags.v, 2'b00,
                                 nxt.flags.d, nxt.flags.i, nxt.flags.z, nxt.flags.c};

endmodule

`default_nettype wire

[src/cpu6502_execute_unit.sv]
// an accepted item is held in the input register, runs through the alu from there and
//    is registered in the result register, which drives rsp valid
// throughput: one item per cycle; the register file is read and written in the same
//    single alu pass, so each item sees the state left by the one before it; the input
//    stalls only while a result waits on rsp and the input register is also full
// reset: synchronous, active high; clears A X Y SP, all flags and both valid bits
`timescale 1ns / 1ps
`default_nettype none

`include "cpu6502_execute_unit_defines.svh"

module cpu6502_execute_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   ceu_req_if.sink    req_bus,
   ceu_rsp_if.source  rsp_bus
);

   // input stage
   ceu_pkg::req_item_type item_ff;
   ceu_pkg::req_item_type item_in;
   logic                  item_valid_ff;

   // result stage
   ceu_pkg::rsp_item_type result_ff;
   ceu_pkg::rsp_item_type result_in;
   logic                  result_valid_ff;

   // architectural registers
   ceu_pkg::state_type    state_ff;
   ceu_pkg::state_type    state_in;

   logic result_free;
   logic advance;
   logic accept;

   // result register can take a new item when empty or being drained this cycle
   assign result_free = !result_valid_ff || rsp_bus.ready;
   // item in the input register executes and retires into the result register
   assign advance     = item_valid_ff && result_free;
   assign req_bus.ready = !item_valid_ff || advance;
   assign accept      = req_bus.valid && req_bus.ready;

   assign item_in.req_type     = req_bus.req_type;
   assign item_in.operand      = req_bus.operand;
   assign item_in.eff_addr     = req_bus.eff_addr;
   assign item_in.jump_target  = req_bus.jump_target;
   assign item_in.current_pc   = req_bus.current_pc;
   assign item_in.page_crossed = req_bus.page_crossed;

   // single pass: decode, alu, flags and next pc
   ceu_alu u_alu (
      .item   (item_ff),
      .cur    (state_ff),
      .nxt    (state_in),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
         state_ff        <= '0;
      end else begin
         if (req_bus.ready) begin
            item_valid_ff <= req_bus.valid;
         end
         if (result_free) begin
            result_valid_ff <= item_valid_ff;
         end
         // state commits together with the result of the same item
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid        = result_valid_ff;
   assign rsp_bus.next_pc      = result_ff.next_pc;
   assign rsp_bus.mem_write    = result_ff.mem_write;
   assign rsp_bus.write_addr   = result_ff.write_addr;
   assign rsp_bus.write_data   = result_ff.write_data;
   assign rsp_bus.extra_cycles = result_ff.extra_cycles;
   assign rsp_bus.acc_value    = result_ff.acc_value;
   assign rsp_bus.x_value      = result_ff.x_value;
   assign rsp_bus.y_value      = result_ff.y_value;
   assign rsp_bus.sp_value     = result_ff.sp_value;
   assign rsp_bus.status_byte  = result_ff.status_byte;

   // a waiting item is never dropped from the input register
   `CEU_ASSERT_RST(a_item_held, clock, reset,
      item_valid_ff && !advance |=> item_valid_ff, "item lost")
   // registers only move when an item retires
   `CEU_ASSERT_RST(a_state_quiet, clock, reset, !advance |=> $stable(state_ff), "state moved")
   // no write means zero address and data
   `CEU_ASSERT_RST(a_no_write_zero, clock, reset,
      result_valid_ff && !result_ff.mem_write |->
         result_ff.write_addr == 16'd0 && result_ff.write_data == 8'd0, "stray write fields")
   // unused status bits and extra cycle code three never appear
   `CEU_ASSERT_RST(a_status_legal, clock, reset,
      result_valid_ff |-> result_ff.status_byte[5:4] == 2'b00 && result_ff.extra_cycles != 2'd3,
      "illegal status or extra")
   // both stages come out of reset empty
   `CEU_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !item_valid_ff && !result_valid_ff,
      "valid after reset")

endmodule

`default_nettype wire

[bench/tb_cpu6502_execute_unit.sv]
`timescale 1ns / 1ps

module tb_cpu6502_execute_unit;

   // selectors past TYA decode as no-ops
   localparam logic [5:0] SEL_UNUSED_LO = 6'd45;
   localparam logic [5:0] SEL_UNUSED_HI = 6'd63;
   localparam int RANDOM_INSTRS = 760;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_AT       = 300;    // retired count that starts the long rsp stall
   localparam int HOLD_CYCLES   = 200;

   typedef struct {
      ceu_pkg::req_item_type instr;
      bit                    drain_first;  // wait for every result before offering this one
   } program_entry_type;

   logic clock;
   logic reset = 1'b1;

   ceu_req_if req_bus ();
   ceu_rsp_if rsp_bus ();

   cpu6502_execute_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // instruction stream and the results it should retire
   program_entry_type     program_q[$];
   ceu_pkg::rsp_item_type retire_q[$];

   // architectural state as the bench sees it
   logic [7:0]         cpu_a, cpu_x, cpu_y, cpu_sp;
   ceu_pkg::flags_type cpu_p;

   int issued_cnt;      // instructions accepted by the block
   int retired_cnt;     // results accepted from the block
   int mismatch_cnt;
   int taken_cnt;
   int write_cnt;
   int gap_cnt;
   int stall_cnt;
   int hold_cnt;
   bit hold_done;
   int cycle_cnt;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   function automatic void set_nz(input logic [7:0] v);
      cpu_p.z = (v == 8'h00);
      cpu_p.n = v[7];
   endfunction

   function automatic void compare_reg(input logic [7:0] reg_val, input logic [7:0] opnd);
      logic [7:0] diff;
      diff    = reg_val - opnd;
      cpu_p.c = (reg_val >= opnd);
      cpu_p.z = (reg_val == opnd);
      cpu_p.n = diff[7];
   endfunction

   // executes one instruction against the bench state and returns what should retire
   function automatic ceu_pkg::rsp_item_type execute_instr(input ceu_pkg::req_item_type r);
      ceu_pkg::rsp_item_type o;
      logic [8:0]   sum;
      logic [7:0]   addend;
      logic         taken;
      logic         pc_penalty;    // ops that take the page-cross penalty
      o          = '0;
      o.next_pc  = r.current_pc;
      taken      = 1'b0;
      pc_penalty = 1'b0;
      case (r.req_type)
         ceu_pkg::OP_ADC, ceu_pkg::OP_SBC: begin
            // no decimal mode, D is ignored; SBC is ADC of the inverted operand
            addend  = (r.req_type == ceu_pkg::OP_SBC) ? ~r.operand : r.operand;
            sum     = {1'b0, cpu_a} + {1'b0, addend} + {8'd0, cpu_p.c};
            cpu_p.v = ~(cpu_a[7] ^ addend[7]) & (cpu_a[7] ^ sum[7]);
            cpu_p.c = sum[8];
            cpu_a   = sum[7:0];
            set_nz(cpu_a);
            pc_penalty = 1'b1;
         end
         ceu_pkg::OP_AND: begin
            cpu_a = cpu_a & r.operand;
            set_nz(cpu_a);
            pc_penalty = 1'b1;
         end
         ceu_pkg::OP_ORA: begin
            cpu_a = cpu_a | r.operand;
            set_nz(cpu_a);
            pc_penalty = 1'b1;
         end
         ceu_pkg::OP_EOR: begin
            cpu_a = cpu_a ^ r.operand;
            set_nz(cpu_a);
            pc_penalty = 1'b1;
         end
         ceu_pkg::OP_ASL: begin
            cpu_p.c = cpu_a[7];
            cpu_a   = {cpu_a[6:0], 1'b0};
            set_nz(cpu_a);
         end
         ceu_pkg::OP_BCC: taken = ~cpu_p.c;
         ceu_pkg::OP_BCS: taken = cpu_p.c;
         ceu_pkg::OP_BEQ: taken = cpu_p.z;
         ceu_pkg::OP_BNE: taken = ~cpu_p.z;
         ceu_pkg::OP_BMI: taken = cpu_p.n;
         ceu_pkg::OP_BPL: taken = ~cpu_p.n;
         ceu_pkg::OP_BVC: taken = ~cpu_p.v;
         ceu_pkg::OP_BVS: taken = cpu_p.v;
         ceu_pkg::OP_BIT: begin
            cpu_p.z = ((cpu_a & r.operand) == 8'h00);
            cpu_p.v = r.operand[6];
            cpu_p.n = r.operand[7];
         end
         ceu_pkg::OP_CLC: cpu_p.c = 1'b0;
         ceu_pkg::OP_CLD: cpu_p.d = 1'b0;
         ceu_pkg::OP_CLI: cpu_p.i = 1'b0;
         ceu_pkg::OP_CLV: cpu_p.v = 1'b0;
         ceu_pkg::OP_SEC: cpu_p.c = 1'b1;
         ceu_pkg::OP_SED: cpu_p.d = 1'b1;
         ceu_pkg::OP_SEI: cpu_p.i = 1'b1;
         ceu_pkg::OP_CMP: begin
            compare_reg(cpu_a, r.operand);
            pc_penalty = 1'b1;
         end
         ceu_pkg::OP_CPX: compare_reg(cpu_x, r.operand);
         ceu_pkg::OP_CPY: compare_reg(cpu_y, r.operand);
         // memory read-modify-write: the new byte goes out on the bus
         ceu_pkg::OP_DEC: begin
            o.mem_write  = 1'b1;
            o.write_data = r.operand - 8'd1;
            set_nz(o.write_data);
         end
         ceu_pkg::OP_INC: begin
            o.mem_write  = 1'b1;
            o.write_data = r.operand + 8'd1;
            set_nz(o.write_data);
         end
         ceu_pkg::OP_DEX: begin cpu_x = cpu_x - 8'd1; set_nz(cpu_x); end
         ceu_pkg::OP_DEY: begin cpu_y = cpu_y - 8'd1; set_nz(cpu_y); end
         ceu_pkg::OP_INX: begin cpu_x = cpu_x + 8'd1; set_nz(cpu_x); end
         ceu_pkg::OP_INY: begin cpu_y = cpu_y + 8'd1; set_nz(cpu_y); end
         ceu_pkg::OP_JMP: o.next_pc = r.jump_target;
         ceu_pkg::OP_LDA: begin cpu_a = r.operand; set_nz(cpu_a); pc_penalty = 1'b1; end
         ceu_pkg::OP_LDX: begin cpu_x = r.operand; set_nz(cpu_x); pc_penalty = 1'b1; end
         ceu_pkg::OP_LDY: begin cpu_y = r.operand; set_nz(cpu_y); pc_penalty = 1'b1; end
         ceu_pkg::OP_STA: begin o.mem_write = 1'b1; o.write_data = cpu_a; end
         ceu_pkg::OP_STX: begin o.mem_write = 1'b1; o.write_data = cpu_x; end
         ceu_pkg::OP_STY: begin o.mem_write = 1'b1; o.write_data = cpu_y; end
         ceu_pkg::OP_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
         ceu_pkg::OP_TAY: begin cpu_y = cpu_a; set_nz(cpu_y); end
         ceu_pkg::OP_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
         ceu_pkg::OP_TXA: begin cpu_a = cpu_x; set_nz(cpu_a); end
         ceu_pkg::OP_TYA: begin cpu_a = cpu_y; set_nz(cpu_a); end
         ceu_pkg::OP_TXS: cpu_sp = cpu_x;      // flags untouched
         default: ;                            // NOP and unused selectors
      endcase

      if (pc_penalty && r.page_crossed)
         o.extra_cycles = ceu_pkg::EXTRA_BRANCH;
      // taken branch: signed offset from the current pc, wrapping in 16 bits
      if (taken) begin
         o.next_pc      = r.current_pc + {{8{r.operand[7]}}, r.operand};
         o.extra_cycles = r.page_crossed ? ceu_pkg::EXTRA_BRPAGE : ceu_pkg::EXTRA_BRANCH;
         taken_cnt++;
      end
      if (o.mem_write) begin
         o.write_addr = r.eff_addr;
         write_cnt++;
      end
      o.acc_value   = cpu_a;
      o.x_value     = cpu_x;
      o.y_value     = cpu_y;
      o.sp_value    = cpu_sp;
      o.status_byte = {cpu_p.n, cpu_p.v, 2'b00, cpu_p.d, cpu_p.i, cpu_p.z, cpu_p.c};
      return o;
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   task automatic queue_instr(input logic [5:0] op, input logic [7:0] opnd,
                              input logic [15:0] eff, input logic [15:0] tgt,
                              input logic [15:0] pc, input logic pcx,
                              input bit drain = 1'b0);
      program_entry_type e;
      e.instr       = {op, opnd, eff, tgt, pc, pcx};
      e.drain_first = drain;
      program_q.push_back(e);
   endtask

   function automatic logic [7:0] pick_operand();
      logic [7:0] corners[4];
      corners = '{8'h00, 8'h7F, 8'h80, 8'hFF};
      if ($urandom_range(0, 7) == 0)
         return corners[$urandom_range(0, 3)];
      return 8'($urandom_range(0, 255));
   endfunction

   // pc biased toward both ends of the address space so branches wrap
   function automatic logic [15:0] pick_pc();
      case ($urandom_range(0, 7))
         0: return 16'($urandom_range(0, 16'h007F));
         1: return 16'($urandom_range(16'hFF80, 16'hFFFF));
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   task automatic queue_random(input logic [5:0] op, input bit drain);
      queue_instr(op, pick_operand(), 16'($urandom_range(0, 16'hFFFF)),
                  16'($urandom_range(0, 16'hFFFF)), pick_pc(), 1'($urandom_range(0, 1)),
                  drain);
   endtask

   // ---------------------------------------------------------------
   // instruction driver, fed from program_q
   // ---------------------------------------------------------------

   always @(posedge clock) begin : drive_instr
      program_entry_type nxt;
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.req_type     <= ceu_pkg::OP_NOP;
         req_bus.operand      <= 8'h00;
         req_bus.eff_addr     <= 16'h0000;
         req_bus.jump_target  <= 16'h0000;
         req_bus.current_pc   <= 16'h0000;
         req_bus.page_crossed <= 1'b0;
         gap_cnt              <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_cnt > 0) begin
            req_bus.valid <= 1'b0;
            gap_cnt       <= gap_cnt - 1;
         end else if (program_q.size() > 0 &&
                      (!program_q[0].drain_first ||
                       (!req_bus.valid && issued_cnt == retired_cnt))) begin
            // a drain item waits with valid low until the pipe is empty
            nxt = program_q.pop_front();
            req_bus.valid        <= 1'b1;
            req_bus.req_type     <= nxt.instr.req_type;
            req_bus.operand      <= nxt.instr.operand;
            req_bus.eff_addr     <= nxt.instr.eff_addr;
            req_bus.jump_target  <= nxt.instr.jump_target;
            req_bus.current_pc   <= nxt.instr.current_pc;
            req_bus.page_crossed <= nxt.instr.page_crossed;
            // every fourth block of 32 instructions goes back to back
            gap_cnt <= ((issued_cnt % 128) >= 96) ? 0 : $urandom_range(0, 7);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // result side: per-item stalls plus one long hold-off
   // ---------------------------------------------------------------

   always @(posedge clock) begin : hold_rsp
      if (reset) begin
         hold_cnt  <= 0;
         hold_done <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (!hold_done && retired_cnt >= HOLD_AT) begin
         hold_cnt  <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin : accept_rsp
      int s;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_cnt     <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            s = ((retired_cnt % 100) < 25) ? 0 : $urandom_range(0, 7);
         else if (stall_cnt > 0)
            s = stall_cnt - 1;
         else
            s = 0;
         stall_cnt     <= s;
         rsp_bus.ready <= (s == 0) && (hold_cnt == 0);
      end
   end

   // ---------------------------------------------------------------
   // monitor: predict on accepted instructions, check retired results
   // ---------------------------------------------------------------

   task automatic check_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatch_cnt++;
         if (mismatch_cnt <= 10)
            $display("mismatch on result %0d, %s: expected %h, got %h",
                     retired_cnt, what, want, got);
      end
   endtask

   always @(posedge clock) begin : watch_buses
      ceu_pkg::req_item_type r;
      ceu_pkg::rsp_item_type got;
      ceu_pkg::rsp_item_type want;
      if (reset) begin
         cpu_a       = 8'h00;
         cpu_x       = 8'h00;
         cpu_y       = 8'h00;
         cpu_sp      = 8'h00;
         cpu_p       = '0;
         issued_cnt  <= 0;
         retired_cnt <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            r = {req_bus.req_type, req_bus.operand, req_bus.eff_addr,
                 req_bus.jump_target, req_bus.current_pc, req_bus.page_crossed};
            retire_q.push_back(execute_instr(r));
            issued_cnt <= issued_cnt + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            retired_cnt <= retired_cnt + 1;
            got = {rsp_bus.next_pc, rsp_bus.mem_write, rsp_bus.write_addr,
                   rsp_bus.write_data, rsp_bus.extra_cycles, rsp_bus.acc_value,
                   rsp_bus.x_value, rsp_bus.y_value, rsp_bus.sp_value,
                   rsp_bus.status_byte};
            if (retire_q.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("result %0d arrived with nothing outstanding", retired_cnt);
            end else begin
               want = retire_q.pop_front();
               check_field("next_pc", want.next_pc, got.next_pc);
               check_field("mem_write", 16'(want.mem_write), 16'(got.mem_write));
               check_field("write_addr", want.write_addr, got.write_addr);
               check_field("write_data", 16'(want.write_data), 16'(got.write_data));
               check_field("extra_cycles", 16'(want.extra_cycles), 16'(got.extra_cycles));
               check_field("acc_value", 16'(want.acc_value), 16'(got.acc_value));
               check_field("x_value", 16'(want.x_value), 16'(got.x_value));
               check_field("y_value", 16'(want.y_value), 16'(got.y_value));
               check_field("sp_value", 16'(want.sp_value), 16'(got.sp_value));
               check_field("status_byte", 16'(want.status_byte), 16'(got.status_byte));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // program and end of run
   // ---------------------------------------------------------------

   initial begin : run_program
      logic [5:0] sweep[64];
      logic [5:0] tmp;
      int         j;
      int         total;
      int         errors;

      // directed: carries, overflow, wrapping branches, bus writes, transfers
      queue_instr(ceu_pkg::OP_LDA, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      queue_instr(ceu_pkg::OP_ADC, 8'h01, 16'h0000, 16'h0000, 16'h0002, 1'b1); // carry, zero
      queue_instr(ceu_pkg::OP_LDA, 8'h7F, 16'h0000, 16'h0000, 16'h0004, 1'b0);
      queue_instr(ceu_pkg::OP_ADC, 8'h01, 16'h0000, 16'h0000, 16'h0006, 1'b0); // overflow
      // taken branch backward across zero, with page penalty
      queue_instr(ceu_pkg::OP_BVS, 8'h80, 16'h0000, 16'h0000, 16'h0010, 1'b1);
      queue_instr(ceu_pkg::OP_BVC, 8'h7F, 16'h0000, 16'h0000, 16'h0012, 1'b1); // not taken
      queue_instr(ceu_pkg::OP_SED, 8'h00, 16'h0000, 16'h0000, 16'h0013, 1'b0);
      // decimal flag set but arithmetic stays binary
      queue_instr(ceu_pkg::OP_SBC, 8'hFF, 16'h0000, 16'h0000, 16'h0015, 1'b1);
      queue_instr(ceu_pkg::OP_ASL, 8'h00, 16'h0000, 16'h0000, 16'h0016, 1'b0);
      // taken branch forward past the top of memory
      queue_instr(ceu_pkg::OP_BCS, 8'h7F, 16'h0000, 16'h0000, 16'hFFF0, 1'b0);
      queue_instr(ceu_pkg::OP_BIT, 8'hC0, 16'h0000, 16'h0000, 16'h0070, 1'b0);
      queue_instr(ceu_pkg::OP_STA, 8'h00, 16'hFFFF, 16'h0000, 16'h0072, 1'b0);
      queue_instr(ceu_pkg::OP_INC, 8'hFF, 16'h0000, 16'h0000, 16'h0074, 1'b1); // wraps to 0
      queue_instr(ceu_pkg::OP_DEC, 8'h00, 16'h1234, 16'h0000, 16'h0076, 1'b0); // wraps to ff
      queue_instr(ceu_pkg::OP_LDX, 8'hFF, 16'h0000, 16'h0000, 16'h0078, 1'b1);
      queue_instr(ceu_pkg::OP_CLC, 8'h00, 16'h0000, 16'h0000, 16'h0079, 1'b0);
      queue_instr(ceu_pkg::OP_TXS, 8'h00, 16'h0000, 16'h0000, 16'h007A, 1'b0); // no flags
      queue_instr(ceu_pkg::OP_TSX, 8'h00, 16'h0000, 16'h0000, 16'h007B, 1'b0);
      queue_instr(ceu_pkg::OP_INX, 8'h00, 16'h0000, 16'h0000, 16'h007C, 1'b0);
      queue_instr(ceu_pkg::OP_DEY, 8'h00, 16'h0000, 16'h0000, 16'h007D, 1'b0);
      queue_instr(ceu_pkg::OP_STX, 8'h00, 16'h8000, 16'h0000, 16'h007E, 1'b0);
      queue_instr(ceu_pkg::OP_STY, 8'h00, 16'h7FFF, 16'h0000, 16'h0080, 1'b0);
      // jump ignores page_crossed
      queue_instr(ceu_pkg::OP_JMP, 8'h00, 16'h0000, 16'hFFFF, 16'h0083, 1'b1);
      queue_instr(SEL_UNUSED_HI, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      queue_instr(SEL_UNUSED_LO, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0);

      // every selector once in shuffled order, first one after a full drain
      for (int i = 0; i < 64; i++)
         sweep[i] = 6'(i);
      for (int i = 63; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = sweep[i];
         sweep[i] = sweep[j];
         sweep[j] = tmp;
      end
      for (int i = 0; i < 64; i++)
         queue_random(sweep[i], i == 0);

      // random mix, mostly implemented ops; two more drained pauses
      for (int i = 0; i < RANDOM_INSTRS; i++) begin
         if ($urandom_range(0, 99) < 8)
            tmp = 6'($urandom_range(SEL_UNUSED_LO, SEL_UNUSED_HI));
         else
            tmp = 6'($urandom_range(ceu_pkg::OP_ADC, ceu_pkg::OP_TYA));
         queue_random(tmp, i == 250 || i == 550);
      end
      total = program_q.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (issued_cnt < total)
         @(posedge clock);
      while (retired_cnt < issued_cnt)
         @(posedge clock);
      // two-stage pipe: keep clocking to catch stray results
      repeat (8) @(posedge clock);

      errors = mismatch_cnt;
      if (retire_q.size() != 0) begin
         errors++;
         $display("%0d results never arrived", retire_q.size());
      end
      $display("ran %0d instructions: %0d taken branches, %0d bus writes,",
               issued_cnt, taken_cnt, write_cnt);
      $display("with random gaps, a %0d-cycle result stall and drained pauses; %0d errors",
               HOLD_CYCLES, errors);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/ceu_pkg.sv
src/ceu_if.sv
src/ceu_alu.sv
src/cpu6502_execute_unit.sv
bench/tb_cpu6502_execute_unit.sv
